// ===== sv/tpcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tpcs_pkg
// Shared types and constants of the top-three-per-category selector.
// ----------------------------------------------------------------------------
package tpcs_pkg;

    localparam int TOP_COUNT  = 3;
    localparam int CAT_NUM    = 4;
    localparam int SLOT_NUM   = CAT_NUM * TOP_COUNT;
    localparam int SLOT_W     = $clog2(SLOT_NUM);
    localparam int NAME_W     = 56;
    localparam int SUBJ_W     = 8;
    localparam int SCORE_W    = 10;
    localparam int CAT_W      = 2;
    localparam int RANK_W     = 2;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 128;

    // Category codes.
    localparam logic [CAT_W-1:0] CAT_TOTAL  = 2'd0;
    localparam logic [CAT_W-1:0] CAT_FIRST  = 2'd1;
    localparam logic [CAT_W-1:0] CAT_SECOND = 2'd2;
    localparam logic [CAT_W-1:0] CAT_THIRD  = 2'd3;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [NAME_W-1:0]  name_high;
        logic [NAME_W-1:0]  name_low;
    } t_entry;

endpackage

// ===== sv/tpcs_cat_list.sv =====
// ----------------------------------------------------------------------------
// tpcs_cat_list
// Sorted best list of one category with registered insertion.
// ----------------------------------------------------------------------------
module tpcs_cat_list
    import tpcs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_ins,
    input  logic   i_clr,
    input  t_entry i_rec,
    output t_entry o_ent [TOP_COUNT],
    output logic   o_vld [TOP_COUNT]
);

    t_entry r_ent [TOP_COUNT];
    logic   r_vld [TOP_COUNT];
    logic   w_behind [TOP_COUNT];
    t_entry n_ent [TOP_COUNT];
    logic   n_vld [TOP_COUNT];

    // A record stays behind an entry unless it has a higher score, or the same
    // score and a smaller name. Full ties therefore keep arrival order.
    always_comb begin
        for (int p = 0; p < TOP_COUNT; p++) begin
            w_behind[p] = r_vld[p] &&
                !((i_rec.score > r_ent[p].score) ||
                  ((i_rec.score == r_ent[p].score) &&
                   ({i_rec.name_high, i_rec.name_low} <
                    {r_ent[p].name_high, r_ent[p].name_low})));
        end
    end

    for (genvar j = 0; j < TOP_COUNT; j++) begin : g_slot
        if (j == 0) begin : g_head
            always_comb begin
                if (w_behind[j]) begin
                    n_ent[j] = r_ent[j];
                    n_vld[j] = r_vld[j];
                end else begin
                    n_ent[j] = i_rec;
                    n_vld[j] = 1'b1;
                end
            end
        end else begin : g_tail
            always_comb begin
                if (w_behind[j]) begin
                    n_ent[j] = r_ent[j];
                    n_vld[j] = r_vld[j];
                end else if (w_behind[j-1]) begin
                    n_ent[j] = i_rec;
                    n_vld[j] = 1'b1;
                end else begin
                    n_ent[j] = r_ent[j-1];
                    n_vld[j] = r_vld[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TOP_COUNT; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_clr) begin
                r_vld[k] <= 1'b0;
            end else if (i_ins) begin
                r_vld[k] <= n_vld[k];
            end
            if (i_ins) begin
                r_ent[k] <= n_ent[k];
            end
        end
    end

    assign o_ent = n_ent;
    assign o_vld = n_vld;

endmodule

// ===== sv/tpcs_emit.sv =====
// ----------------------------------------------------------------------------
// tpcs_emit
// Snapshots all lists; emits the valid entries one per cycle unless stalled.
// ----------------------------------------------------------------------------
module tpcs_emit
    import tpcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_entry                i_ent [SLOT_NUM],
    input  logic                  i_vld [SLOT_NUM],
    output logic                  o_load_rdy,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    t_entry            r_ent [SLOT_NUM];
    logic              r_vld [SLOT_NUM];
    logic              r_busy;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] w_first;
    logic [SLOT_W-1:0] w_next;
    logic              w_last;
    logic              w_take;
    logic [CAT_W-1:0]  w_cat  [SLOT_NUM];
    logic [RANK_W-1:0] w_rank [SLOT_NUM];
    t_entry            w_cur;

    for (genvar c = 0; c < CAT_NUM; c++) begin : g_cat
        for (genvar r = 0; r < TOP_COUNT; r++) begin : g_rank
            assign w_cat[c*TOP_COUNT+r]  = CAT_W'(c);
            assign w_rank[c*TOP_COUNT+r] = RANK_W'(r);
        end
    end

    // Lowest valid slot of a new snapshot, and the next valid slot after the
    // current one.
    always_comb begin
        w_first = '0;
        w_next  = '0;
        w_last  = 1'b1;
        for (int k = SLOT_NUM - 1; k >= 0; k--) begin
            if (i_vld[k]) begin
                w_first = SLOT_W'(k);
            end
            if (r_vld[k] && (SLOT_W'(k) > r_idx)) begin
                w_next = SLOT_W'(k);
                w_last = 1'b0;
            end
        end
    end

    assign w_take     = r_busy && m_axis_tready;
    assign o_load_rdy = !r_busy || (w_take && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= w_first;
        end else if (w_take) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= w_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_ent;
            r_vld <= i_vld;
        end
    end

    assign w_cur         = r_ent[r_idx];
    assign m_axis_tvalid = r_busy;
    assign m_axis_tlast  = w_last;
    assign m_axis_tdata  = {2'b00, w_cur.score, w_cur.name_low, w_cur.name_high,
                            w_rank[r_idx], w_cat[r_idx]};

endmodule

// ===== sv/top_three_per_category_select_top.sv =====
// ----------------------------------------------------------------------------
// top_three_per_category_select_top
// Keeps the three best records per category and reports them per group.
// ----------------------------------------------------------------------------
// The block takes one record per cycle. Each record is inserted into four
// sorted lists (total score and each subject) as it leaves the input register.
// The record flagged by tlast closes the group: the lists including that record
// are copied to the result buffer and cleared, and the valid entries then leave
// one per cycle while the receiver is ready, at most twelve, category by
// category and rank by rank, with tlast on the final one. Records of the next
// group keep flowing at one per cycle while results drain; only a group-ending
// record waits in the input register until the previous group's last result
// has been taken, since the result buffer holds one group at a time.
module top_three_per_category_select_top
    import tpcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, from bit 0: name_high[55:0], name_low[55:0], score_first[7:0],
    // score_second[7:0], score_third[7:0]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, from bit 0: category[1:0], rank[1:0], winner_high[55:0],
    // winner_low[55:0], winner_score[9:0], two zero bits
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    logic              r_in_vld;
    logic              r_in_last;
    logic [NAME_W-1:0] r_in_high;
    logic [NAME_W-1:0] r_in_low;
    logic [SUBJ_W-1:0] r_in_s1;
    logic [SUBJ_W-1:0] r_in_s2;
    logic [SUBJ_W-1:0] r_in_s3;

    logic   w_load_rdy;
    logic   w_consume;
    logic   w_load;
    t_entry w_rec  [CAT_NUM];
    t_entry w_snap [SLOT_NUM];
    logic   w_svld [SLOT_NUM];

    assign w_consume     = r_in_vld && (!r_in_last || w_load_rdy);
    assign w_load        = w_consume && r_in_last;
    assign s_axis_tready = !r_in_vld || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_high <= s_axis_tdata[55:0];
            r_in_low  <= s_axis_tdata[111:56];
            r_in_s1   <= s_axis_tdata[119:112];
            r_in_s2   <= s_axis_tdata[127:120];
            r_in_s3   <= s_axis_tdata[135:128];
            r_in_last <= s_axis_tlast;
        end
    end

    always_comb begin
        for (int c = 0; c < CAT_NUM; c++) begin
            w_rec[c].name_high = r_in_high;
            w_rec[c].name_low  = r_in_low;
        end
        w_rec[CAT_TOTAL].score  = SCORE_W'(r_in_s1) + SCORE_W'(r_in_s2)
                                + SCORE_W'(r_in_s3);
        w_rec[CAT_FIRST].score  = SCORE_W'(r_in_s1);
        w_rec[CAT_SECOND].score = SCORE_W'(r_in_s2);
        w_rec[CAT_THIRD].score  = SCORE_W'(r_in_s3);
    end

    for (genvar c = 0; c < CAT_NUM; c++) begin : g_list
        t_entry w_ent [TOP_COUNT];
        logic   w_vld [TOP_COUNT];

        tpcs_cat_list u_list (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ins   (w_consume),
            .i_clr   (w_load),
            .i_rec   (w_rec[c]),
            .o_ent   (w_ent),
            .o_vld   (w_vld)
        );

        for (genvar r = 0; r < TOP_COUNT; r++) begin : g_slot
            assign w_snap[c*TOP_COUNT+r] = w_ent[r];
            assign w_svld[c*TOP_COUNT+r] = w_vld[r];
        end
    end

    tpcs_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_ent         (w_snap),
        .i_vld         (w_svld),
        .o_load_rdy    (w_load_rdy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== sv/tpcs_checker.sv =====
// ----------------------------------------------------------------------------
// tpcs_checker
// Port-level checks of the top-three-per-category selector.
// ----------------------------------------------------------------------------
module tpcs_checker
    import tpcs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    logic w_out_req;

    assign w_out_req = m_axis_tvalid && m_axis_tready;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

    // Results of a group follow each other without gaps.
    a_group_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_req && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a group of results");

    // A group that follows straight after another opens with the best total.
    a_group_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_req && m_axis_tlast |=> !m_axis_tvalid ||
            (m_axis_tdata[1:0] == CAT_TOTAL && m_axis_tdata[3:2] == 2'd0))
        else $error("group does not start at the best total");

    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[3:2]) < TOP_COUNT) ||
                          (TOP_COUNT > 4))
        else $error("rank out of range");

endmodule

bind top_three_per_category_select_top tpcs_checker u_tpcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Top-three-per-category selector testbench
// Streams groups of named score records into the block and checks every
// reported winner against a scoreboard that keeps its own sorted lists per
// category. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import tpcs_pkg::*;

    typedef struct packed {
        logic [NAME_W-1:0] name_high;
        logic [NAME_W-1:0] name_low;
        logic [SUBJ_W-1:0] score_first;
        logic [SUBJ_W-1:0] score_second;
        logic [SUBJ_W-1:0] score_third;
        logic              group_end;
    } t_record;

    typedef struct packed {
        logic [CAT_W-1:0]   category;
        logic [RANK_W-1:0]  rank;
        logic [NAME_W-1:0]  winner_high;
        logic [NAME_W-1:0]  winner_low;
        logic [SCORE_W-1:0] winner_score;
        logic               run_last;
    } t_winner;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // Scoreboard copy of the ranking lists, category-major.
    logic [NAME_W-1:0]  board_high  [SLOT_NUM];
    logic [NAME_W-1:0]  board_low   [SLOT_NUM];
    logic [SCORE_W-1:0] board_score [SLOT_NUM];
    logic               board_used  [SLOT_NUM];

    t_winner winners_due[$];

    bit steady;
    int n_records;
    int n_groups;
    int n_winners;
    int n_errors;

    top_three_per_category_select_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void clear_board();
        for (int k = 0; k < SLOT_NUM; k++) begin
            board_used[k] = 1'b0;
        end
    endfunction

    // True when the candidate ranks strictly ahead of slot k.
    function automatic bit outranks(int k, logic [SCORE_W-1:0] s,
                                    logic [NAME_W-1:0] nh, logic [NAME_W-1:0] nl);
        if (s != board_score[k])
            return s > board_score[k];
        if (nh != board_high[k])
            return nh < board_high[k];
        return nl < board_low[k];
    endfunction

    function automatic void place_in_category(logic [CAT_W-1:0] cat,
                                              logic [SCORE_W-1:0] s,
                                              logic [NAME_W-1:0] nh,
                                              logic [NAME_W-1:0] nl);
        int base;
        int p;
        base = int'(cat) * TOP_COUNT;
        p = 0;
        while (p < TOP_COUNT && board_used[base + p] && !outranks(base + p, s, nh, nl))
            p++;
        if (p < TOP_COUNT) begin
            for (int j = TOP_COUNT - 1; j > p; j--) begin
                board_high[base + j]  = board_high[base + j - 1];
                board_low[base + j]   = board_low[base + j - 1];
                board_score[base + j] = board_score[base + j - 1];
                board_used[base + j]  = board_used[base + j - 1];
            end
            board_high[base + p]  = nh;
            board_low[base + p]   = nl;
            board_score[base + p] = s;
            board_used[base + p]  = 1'b1;
        end
    endfunction

    // Takes in one accepted record and, at the end of a group, queues the winners.
    function automatic void absorb_record(t_record rec);
        logic [SCORE_W-1:0] total;
        t_winner w;
        int first_new;
        total = SCORE_W'(rec.score_first) + SCORE_W'(rec.score_second)
              + SCORE_W'(rec.score_third);
        place_in_category(CAT_TOTAL, total, rec.name_high, rec.name_low);
        place_in_category(CAT_FIRST, SCORE_W'(rec.score_first), rec.name_high, rec.name_low);
        place_in_category(CAT_SECOND, SCORE_W'(rec.score_second), rec.name_high, rec.name_low);
        place_in_category(CAT_THIRD, SCORE_W'(rec.score_third), rec.name_high, rec.name_low);
        n_records++;
        if (rec.group_end) begin
            first_new = winners_due.size();
            for (int c = 0; c < CAT_NUM; c++) begin
                for (int r = 0; r < TOP_COUNT; r++) begin
                    if (board_used[c * TOP_COUNT + r]) begin
                        w.category     = CAT_W'(c);
                        w.rank         = RANK_W'(r);
                        w.winner_high  = board_high[c * TOP_COUNT + r];
                        w.winner_low   = board_low[c * TOP_COUNT + r];
                        w.winner_score = board_score[c * TOP_COUNT + r];
                        w.run_last     = 1'b0;
                        winners_due.push_back(w);
                    end
                end
            end
            if (winners_due.size() > first_new)
                winners_due[winners_due.size() - 1].run_last = 1'b1;
            clear_board();
            n_groups++;
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on result %0d, %s: got 0x%0h, want 0x%0h",
                 $time, n_winners, what, got, want);
        n_errors++;
    endtask

    task automatic check_winner(logic [OUT_DATA_W-1:0] data, logic last);
        t_winner w;
        if (winners_due.size() == 0) begin
            report_mismatch("result with nothing pending", data[63:0], 64'd0);
        end else begin
            w = winners_due.pop_front();
            if (data[1:0] != w.category)
                report_mismatch("category", 64'(data[1:0]), 64'(w.category));
            if (data[3:2] != w.rank)
                report_mismatch("rank", 64'(data[3:2]), 64'(w.rank));
            if (data[59:4] != w.winner_high)
                report_mismatch("winner_high", 64'(data[59:4]), 64'(w.winner_high));
            if (data[115:60] != w.winner_low)
                report_mismatch("winner_low", 64'(data[115:60]), 64'(w.winner_low));
            if (data[125:116] != w.winner_score)
                report_mismatch("winner_score", 64'(data[125:116]), 64'(w.winner_score));
            if (data[127:126] != 2'b00)
                report_mismatch("padding", 64'(data[127:126]), 64'd0);
            if (last != w.run_last)
                report_mismatch("run_last", 64'(last), 64'(w.run_last));
        end
        n_winners++;
    endtask

    // Result side: sample at each edge, then decide whether to stall next cycle.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                check_winner(m_axis_tdata, m_axis_tlast);
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    // Offers one request and holds it until the block takes it.
    task automatic send_record(t_record rec);
        while (!steady && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rec.score_third, rec.score_second, rec.score_first,
                          rec.name_low, rec.name_high};
        s_axis_tlast  <= rec.group_end;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        absorb_record(rec);
    endtask

    // Name from text: character 0 lands in the top byte, zero padded.
    function automatic logic [2*NAME_W-1:0] text_name(string s);
        logic [2*NAME_W-1:0] v;
        v = '0;
        for (int i = 0; i < 14; i++) begin
            v = {v[2*NAME_W-9:0], (i < s.len()) ? s[i] : 8'h00};
        end
        return v;
    endfunction

    function automatic t_record make_rec(logic [2*NAME_W-1:0] nm, logic [SUBJ_W-1:0] a,
                                         logic [SUBJ_W-1:0] b, logic [SUBJ_W-1:0] c,
                                         logic ends);
        t_record rec;
        rec.name_high    = nm[2*NAME_W-1:NAME_W];
        rec.name_low     = nm[NAME_W-1:0];
        rec.score_first  = a;
        rec.score_second = b;
        rec.score_third  = c;
        rec.group_end    = ends;
        return rec;
    endfunction

    function automatic logic [2*NAME_W-1:0] random_name();
        logic [2*NAME_W-1:0] v;
        logic [127:0]        raw;
        int len;
        case ($urandom_range(0, 2))
            0: begin
                raw = {$urandom, $urandom, $urandom, $urandom};
                v   = raw[2*NAME_W-1:0];
            end
            1: begin
                v = '0;
                len = $urandom_range(1, 14);
                for (int i = 0; i < 14; i++) begin
                    v = {v[2*NAME_W-9:0],
                         (i < len) ? 8'(8'h41 + $urandom_range(0, 25)) : 8'h00};
                end
            end
            default: begin
                // A small pool, so that names and full records repeat.
                case ($urandom_range(0, 3))
                    0: v = text_name("MORGAN");
                    1: v = text_name("MORGANA");
                    2: v = text_name("ABCDEFGHIJKLMN");
                    default: v = text_name("ABCDEFGHIJKLMO");
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [SUBJ_W-1:0] random_score();
        if ($urandom_range(0, 99) < 30) begin
            case ($urandom_range(0, 4))
                0: return 8'd0;
                1: return 8'd1;
                2: return 8'd100;
                3: return 8'd254;
                default: return 8'd255;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_extremes();
        // Groups of one and two: only the entries present may be reported.
        send_record(make_rec('0, 8'd0, 8'd0, 8'd0, 1'b1));
        send_record(make_rec('1, 8'd255, 8'd255, 8'd255, 1'b1));
        send_record(make_rec(text_name("ALICE"), 8'd255, 8'd0, 8'd128, 1'b0));
        send_record(make_rec(text_name("BOB"), 8'd0, 8'd255, 8'd128, 1'b1));
    endtask

    task automatic test_ordering();
        // Equal scores fall back on name order, then on the low half of the name.
        send_record(make_rec(text_name("DAVE"), 8'd50, 8'd60, 8'd70, 1'b0));
        send_record(make_rec(text_name("CAROL"), 8'd50, 8'd60, 8'd70, 1'b0));
        send_record(make_rec(text_name("ABCDEFGHIJKLMO"), 8'd50, 8'd60, 8'd70, 1'b0));
        send_record(make_rec(text_name("ABCDEFGHIJKLMN"), 8'd50, 8'd60, 8'd70, 1'b0));
        send_record(make_rec(text_name("EVE"), 8'd50, 8'd60, 8'd70, 1'b1));
        // Full ties, then entries that land at the front, the middle and the end.
        send_record(make_rec(text_name("TWIN"), 8'd10, 8'd10, 8'd10, 1'b0));
        send_record(make_rec(text_name("TWIN"), 8'd10, 8'd10, 8'd10, 1'b0));
        send_record(make_rec(text_name("TOP"), 8'd200, 8'd5, 8'd20, 1'b0));
        send_record(make_rec(text_name("MID"), 8'd100, 8'd10, 8'd10, 1'b0));
        send_record(make_rec(text_name("LOW"), 8'd1, 8'd255, 8'd9, 1'b0));
        send_record(make_rec(text_name("ZED"), 8'd10, 8'd10, 8'd10, 1'b1));
    endtask

    task automatic test_back_to_back();
        // Group ends arriving while the previous group is still draining.
        steady = 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_record(make_rec(random_name(), random_score(), random_score(),
                                 random_score(), 1'b1));
        end
        steady = 1'b0;
    endtask

    task automatic test_random_groups(int target);
        int size;
        int sent;
        sent = 0;
        while (sent < target) begin
            steady = (sent > target / 3) && (sent < target / 2);
            size = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 8);
            for (int i = 0; i < size; i++) begin
                send_record(make_rec(random_name(), random_score(), random_score(),
                                     random_score(), i == size - 1));
            end
            sent += size;
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        steady    = 1'b0;
        n_records = 0;
        n_groups  = 0;
        n_winners = 0;
        n_errors  = 0;
        clear_board();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_ordering();
        test_back_to_back();
        test_random_groups(160);

        s_axis_tvalid <= 1'b0;
        while (winners_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d records in %0d groups; %0d winners were reported and checked.",
                 n_records, n_groups, n_winners);
        $display("Covered score and name ties, groups of one to eight and back-to-back ends.");
        if (n_errors == 0 && winners_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
